### hw/rtl/rucst_pkg.sv
`timescale 1ns / 1ps
package rucst_pkg;

  localparam int unsigned FRAC_BITS   = 16;
  localparam int unsigned INDEX_WIDTH = 16;
  localparam int unsigned EPS_WIDTH   = 16;

  // one quotient bit per divider stage
  localparam int unsigned DIV_STEPS = 32;

  // two-entry queues, power-of-two depth so pointers wrap on their own
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPW    = $clog2(QDEPTH);
  localparam int unsigned QCW    = $clog2(QDEPTH + 1);

  localparam logic signed [32:0] ONE_Q   = 33'sd1 <<< FRAC_BITS;
  localparam logic signed [31:0] SAT_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

  // sign class of a slab numerator, used on parallel axes
  typedef enum logic [1:0] {
    BND_ZERO = 2'd0,
    BND_POS  = 2'd1,
    BND_NEG  = 2'd2
  } bnd_e;

  // classified request between front and back
  typedef struct packed {
    logic [2:0][31:0]        lo_mag;
    logic [2:0][31:0]        hi_mag;
    logic [2:0][31:0]        d_mag;
    logic [2:0]              lo_neg;
    logic [2:0]              hi_neg;
    bnd_e [2:0]              lo_code;
    bnd_e [2:0]              hi_code;
    logic [2:0]              par;
    logic [INDEX_WIDTH-1:0]  index;
  } cls_t;

  // data riding beside the dividers
  typedef struct packed {
    bnd_e [2:0]              lo_code;
    bnd_e [2:0]              hi_code;
    logic [2:0]              par;
    logic [INDEX_WIDTH-1:0]  index;
  } side_t;

  typedef struct packed {
    logic                    hit;
    logic signed [31:0]      t_near;
    logic signed [31:0]      t_far;
    logic [INDEX_WIDTH-1:0]  index;
  } res_t;

endpackage

### hw/rtl/rucst_front.sv
`timescale 1ns / 1ps
module rucst_front (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  input  logic [rucst_pkg::EPS_WIDTH-1:0]      cfg_data_i,
  input  logic                                 push_i,
  output logic                                 full_o,
  input  logic [2:0][31:0]                     org_i,
  input  logic [2:0][31:0]                     dir_i,
  input  logic [rucst_pkg::INDEX_WIDTH-1:0]    index_i,
  output logic                                 avail_o,
  input  logic                                 pop_i,
  output rucst_pkg::cls_t                      head_o
);

  logic [rucst_pkg::EPS_WIDTH-1:0] eps_q;
  rucst_pkg::cls_t                 cls;
  rucst_pkg::cls_t                 mem_q [rucst_pkg::QDEPTH];
  logic [rucst_pkg::QPW-1:0]       wp_q, rp_q;
  logic [rucst_pkg::QCW-1:0]       cnt_q, cnt_d;
  logic                            do_push, do_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q <= rucst_pkg::EPS_WIDTH'(7);
    end else if (cfg_valid_i) begin
      eps_q <= cfg_data_i;
    end
  end

  // per-axis classification
  always_comb begin
    logic signed [32:0] o_ext, d_ext, n_lo, n_hi, d_neg;
    cls       = '0;
    cls.index = index_i;
    for (int i = 0; i < 3; i++) begin
      o_ext = {org_i[i][31], org_i[i]};
      d_ext = {dir_i[i][31], dir_i[i]};
      n_lo  = -rucst_pkg::ONE_Q - o_ext;
      n_hi  = rucst_pkg::ONE_Q - o_ext;
      d_neg = -d_ext;
      cls.lo_mag[i] = n_lo[32] ? 32'(-n_lo) : n_lo[31:0];
      cls.hi_mag[i] = n_hi[32] ? 32'(-n_hi) : n_hi[31:0];
      cls.d_mag[i]  = dir_i[i][31] ? d_neg[31:0] : dir_i[i];
      cls.lo_neg[i] = n_lo[32] ^ dir_i[i][31];
      cls.hi_neg[i] = n_hi[32] ^ dir_i[i][31];
      cls.par[i]    = (dir_i[i] == '0) ||
                      (cls.d_mag[i] < {{(32-rucst_pkg::EPS_WIDTH){1'b0}}, eps_q});
      cls.lo_code[i] = (n_lo == '0) ? rucst_pkg::BND_ZERO :
                       (n_lo[32] ? rucst_pkg::BND_NEG : rucst_pkg::BND_POS);
      cls.hi_code[i] = (n_hi == '0) ? rucst_pkg::BND_ZERO :
                       (n_hi[32] ? rucst_pkg::BND_NEG : rucst_pkg::BND_POS);
    end
  end

  // request queue toward the back end
  assign full_o  = (cnt_q == rucst_pkg::QCW'(rucst_pkg::QDEPTH));
  assign avail_o = (cnt_q != '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && avail_o;
  assign head_o  = mem_q[rp_q];
  assign cnt_d   = cnt_q + rucst_pkg::QCW'(do_push) - rucst_pkg::QCW'(do_pop);

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wp_q] <= cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wp_q <= wp_q + 1'b1;
      end
      if (do_pop) begin
        rp_q <= rp_q + 1'b1;
      end
    end
  end

endmodule

### hw/rtl/rucst_div.sv
`timescale 1ns / 1ps
module rucst_div (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [31:0]        num_i,
  input  logic [31:0]        den_i,
  input  logic               neg_i,
  output logic signed [31:0] q_o
);

  localparam int unsigned N = rucst_pkg::DIV_STEPS;

  logic [31:0] rem_q [N+1];
  logic [31:0] low_q [N+1];
  logic [31:0] quo_q [N+1];
  logic [31:0] den_q [N+1];
  logic        neg_q [N+1];
  logic        ovf_q [N+1];

  logic [31:0] hi0;
  logic        ovf0;

  // upper dividend bits; quotient needs more than 32 bits when they reach the divisor
  assign hi0  = num_i >> (32 - rucst_pkg::FRAC_BITS);
  assign ovf0 = (hi0 >= den_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= ovf0 ? '0 : hi0;
      low_q[0] <= num_i << rucst_pkg::FRAC_BITS;
      quo_q[0] <= '0;
      den_q[0] <= den_i;
      neg_q[0] <= neg_i;
      ovf_q[0] <= ovf0;
    end
  end

  for (genvar k = 1; k <= N; k++) begin : g_step
    logic [32:0] trial, diff;
    logic        ge;
    assign trial = {rem_q[k-1], low_q[k-1][31]};
    assign ge    = (trial >= {1'b0, den_q[k-1]});
    assign diff  = trial - {1'b0, den_q[k-1]};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? diff[31:0] : trial[31:0];
        low_q[k] <= {low_q[k-1][30:0], 1'b0};
        quo_q[k] <= {quo_q[k-1][30:0], ge};
        den_q[k] <= den_q[k-1];
        neg_q[k] <= neg_q[k-1];
        ovf_q[k] <= ovf_q[k-1];
      end
    end
  end

  // apply sign and saturate
  always_comb begin
    if (neg_q[N]) begin
      if (ovf_q[N] || (quo_q[N] > 32'h8000_0000)) begin
        q_o = rucst_pkg::SAT_MIN;
      end else begin
        q_o = $signed(-quo_q[N]);
      end
    end else begin
      if (ovf_q[N] || quo_q[N][31]) begin
        q_o = rucst_pkg::SAT_MAX;
      end else begin
        q_o = $signed(quo_q[N]);
      end
    end
  end

endmodule

### hw/rtl/rucst_back.sv
`timescale 1ns / 1ps
module rucst_back (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               avail_i,
  output logic                               take_o,
  input  rucst_pkg::cls_t                    head_i,
  output logic                               empty_o,
  input  logic                               pop_i,
  output rucst_pkg::res_t                    res_o
);

  localparam int unsigned N = rucst_pkg::DIV_STEPS;

  logic                      en;
  logic [N:0]                vld_q;
  rucst_pkg::side_t          side_q [N+1];
  logic signed [2:0][31:0]   q_lo, q_hi;
  logic signed [2:0][31:0]   a_q, b_q, lo_q, hi_q;
  logic                      s1_vld_q, s2_vld_q, s3_vld_q;
  logic [rucst_pkg::INDEX_WIDTH-1:0] idx1_q, idx2_q, idx3_q;
  logic signed [31:0]        tn_q, tf_q;
  rucst_pkg::res_t           res;
  rucst_pkg::res_t           mem_q [rucst_pkg::QDEPTH];
  logic [rucst_pkg::QPW-1:0] wp_q, rp_q;
  logic [rucst_pkg::QCW-1:0] cnt_q;
  logic                      do_push, do_pop;

  function automatic logic signed [31:0] par_bound(rucst_pkg::bnd_e c);
    case (c)
      rucst_pkg::BND_POS: par_bound = rucst_pkg::SAT_MAX;
      rucst_pkg::BND_NEG: par_bound = rucst_pkg::SAT_MIN;
      default:            par_bound = '0;
    endcase
  endfunction

  // whole pipeline advances while the result queue has room
  assign en     = (cnt_q != rucst_pkg::QCW'(rucst_pkg::QDEPTH));
  assign take_o = en && avail_i;

  for (genvar i = 0; i < 3; i++) begin : g_axis
    rucst_div u_div_lo (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (head_i.lo_mag[i]),
      .den_i (head_i.d_mag[i]),
      .neg_i (head_i.lo_neg[i]),
      .q_o   (q_lo[i])
    );
    rucst_div u_div_hi (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (head_i.hi_mag[i]),
      .den_i (head_i.d_mag[i]),
      .neg_i (head_i.hi_neg[i]),
      .q_o   (q_hi[i])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0].lo_code <= head_i.lo_code;
      side_q[0].hi_code <= head_i.hi_code;
      side_q[0].par     <= head_i.par;
      side_q[0].index   <= head_i.index;
      for (int k = 1; k <= N; k++) begin
        side_q[k] <= side_q[k-1];
      end
      // parallel override
      for (int i = 0; i < 3; i++) begin
        a_q[i] <= side_q[N].par[i] ? par_bound(side_q[N].lo_code[i]) : q_lo[i];
        b_q[i] <= side_q[N].par[i] ? par_bound(side_q[N].hi_code[i]) : q_hi[i];
      end
      idx1_q <= side_q[N].index;
      // order each slab, slices of a packed array compare as signed only by cast
      for (int i = 0; i < 3; i++) begin
        lo_q[i] <= ($signed(a_q[i]) > $signed(b_q[i])) ? b_q[i] : a_q[i];
        hi_q[i] <= ($signed(a_q[i]) > $signed(b_q[i])) ? a_q[i] : b_q[i];
      end
      idx2_q <= idx1_q;
      idx3_q <= idx2_q;
    end
  end

  // largest near, smallest far
  always_ff @(posedge clk_i) begin
    logic signed [31:0] tn, tf;
    tn = lo_q[0];
    tf = hi_q[0];
    for (int i = 1; i < 3; i++) begin
      if ($signed(lo_q[i]) > tn) tn = lo_q[i];
      if ($signed(hi_q[i]) < tf) tf = hi_q[i];
    end
    if (en) begin
      tn_q <= tn;
      tf_q <= tf;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
    end else if (en) begin
      vld_q    <= {vld_q[N-1:0], avail_i};
      s1_vld_q <= vld_q[N];
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
    end
  end

  // result queue
  assign res.hit    = (tn_q <= tf_q);
  assign res.t_near = tn_q;
  assign res.t_far  = tf_q;
  assign res.index  = idx3_q;
  assign do_push    = en && s3_vld_q;
  assign empty_o    = (cnt_q == '0);
  assign do_pop     = pop_i && !empty_o;
  assign res_o      = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wp_q] <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_q + rucst_pkg::QCW'(do_push) - rucst_pkg::QCW'(do_pop);
      if (do_push) begin
        wp_q <= wp_q + 1'b1;
      end
      if (do_pop) begin
        rp_q <= rp_q + 1'b1;
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= rucst_pkg::QCW'(rucst_pkg::QDEPTH))
    else $error("result queue overflow");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q) && $stable(s3_vld_q))
    else $error("pipeline moved while result queue full");

  a_push_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_push |=> !empty_o)
    else $error("pushed result not visible");

  a_take_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_o |-> en && avail_i)
    else $error("request taken while stalled");

endmodule

### hw/rtl/ray_unit_cube_slab_test_unit.sv
`timescale 1ns / 1ps
// ray versus unit cube slab test
// input side looks like a queue: drive the ray fields and object_index_i and
// raise push; the request is taken at a clock edge with push high and full low
// result side: while empty is low the oldest result sits on hit_o, t_near_o,
// t_far_o and hit_index_o; it is taken at an edge with pop high and empty low
// configuration: cfg_data_i sets parallel_epsilon at an edge with cfg_valid_i
// high; cfg_ready_o is always high; write only while no request is in flight
// a request taken at an edge passes the 2-entry request queue, 33 divider
// stages, 3 combine stages and the result queue on its way to the result side
// throughput: one request per cycle while the result queue has room, set by
// the six pipelined dividers, each producing one quotient bit per stage
// when pop stays low the result queue fills, the back pipeline freezes in
// place, then the request queue fills and full rises; nothing is dropped
// reset clears both queues and the pipeline valids and sets epsilon to 7
module ray_unit_cube_slab_test_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [rucst_pkg::EPS_WIDTH-1:0]      cfg_data_i,
  input  logic                                 push,
  output logic                                 full,
  input  logic signed [31:0]                   origin_x_i,
  input  logic signed [31:0]                   origin_y_i,
  input  logic signed [31:0]                   origin_z_i,
  input  logic signed [31:0]                   dir_x_i,
  input  logic signed [31:0]                   dir_y_i,
  input  logic signed [31:0]                   dir_z_i,
  input  logic [rucst_pkg::INDEX_WIDTH-1:0]    object_index_i,
  output logic                                 empty,
  input  logic                                 pop,
  output logic                                 hit_o,
  output logic signed [31:0]                   t_near_o,
  output logic signed [31:0]                   t_far_o,
  output logic [rucst_pkg::INDEX_WIDTH-1:0]    hit_index_o
);

  rucst_pkg::cls_t head;
  rucst_pkg::res_t res;
  logic            avail, take;

  // register is always writable
  assign cfg_ready_o = 1'b1;

  // front: classify each ray and queue it
  rucst_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .push_i      (push),
    .full_o      (full),
    .org_i       ({origin_z_i, origin_y_i, origin_x_i}),
    .dir_i       ({dir_z_i, dir_y_i, dir_x_i}),
    .index_i     (object_index_i),
    .avail_o     (avail),
    .pop_i       (take),
    .head_o      (head)
  );

  // back: divide, order, reduce, queue results
  rucst_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .avail_i (avail),
    .take_o  (take),
    .head_i  (head),
    .empty_o (empty),
    .pop_i   (pop),
    .res_o   (res)
  );

  assign hit_o       = res.hit;
  assign t_near_o    = res.t_near;
  assign t_far_o     = res.t_far;
  assign hit_index_o = res.index;

endmodule

### verif/tb_ray_unit_cube_slab_test_unit.sv
`timescale 1ns / 1ps
module tb_ray_unit_cube_slab_test_unit;

  localparam int unsigned LATENCY = 37;

  typedef struct packed {
    logic signed [31:0]                ox;
    logic signed [31:0]                oy;
    logic signed [31:0]                oz;
    logic signed [31:0]                dx;
    logic signed [31:0]                dy;
    logic signed [31:0]                dz;
    logic [rucst_pkg::INDEX_WIDTH-1:0] idx;
  } ray_t;

  logic                              clk_i;
  logic                              rst_ni;
  logic                              cfg_valid_i;
  logic                              cfg_ready_o;
  logic [rucst_pkg::EPS_WIDTH-1:0]   cfg_data_i;
  logic                              push;
  logic                              full;
  logic signed [31:0]                origin_x_i, origin_y_i, origin_z_i;
  logic signed [31:0]                dir_x_i, dir_y_i, dir_z_i;
  logic [rucst_pkg::INDEX_WIDTH-1:0] object_index_i;
  logic                              empty;
  logic                              pop;
  logic                              hit_o;
  logic signed [31:0]                t_near_o, t_far_o;
  logic [rucst_pkg::INDEX_WIDTH-1:0] hit_index_o;

  ray_unit_cube_slab_test_unit DUT (.*);

  // testbench copy of the epsilon register
  logic [rucst_pkg::EPS_WIDTH-1:0] eps_model;
  ray_t            pending_rays[$];
  rucst_pkg::res_t expected_hits[$];
  int   errors;
  int   push_idle_pct;
  int   pop_idle_pct;
  int   hold_pop_cycles;
  bit   hold_pop_req;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // one slab bound: (num << FRAC_BITS) / d, truncated, saturated; parallel gives the saturated sign of num or zero
  function automatic longint slab_bound(longint num, longint d, bit par);
    longint q;
    if (par) begin
      if (num > 0) return 64'sd2147483647;
      if (num < 0) return -64'sd2147483648;
      return 0;
    end
    q = (num * (64'sd1 <<< rucst_pkg::FRAC_BITS)) / d;
    if (q > 64'sd2147483647) q = 64'sd2147483647;
    if (q < -64'sd2147483648) q = -64'sd2147483648;
    return q;
  endfunction

  function automatic rucst_pkg::res_t clip_ray(ray_t r);
    longint o[3], d[3], lo, hi, tmp, mag, one, tn, tf;
    bit par;
    rucst_pkg::res_t res;
    o[0] = r.ox; o[1] = r.oy; o[2] = r.oz;
    d[0] = r.dx; d[1] = r.dy; d[2] = r.dz;
    one = 64'sd1 <<< rucst_pkg::FRAC_BITS;
    tn = 0;
    tf = 0;
    for (int a = 0; a < 3; a++) begin
      mag = d[a] < 0 ? -d[a] : d[a];
      par = (d[a] == 0) || (mag < longint'(eps_model));
      lo = slab_bound(-one - o[a], d[a], par);
      hi = slab_bound(one - o[a], d[a], par);
      if (lo > hi) begin
        tmp = lo; lo = hi; hi = tmp;
      end
      // first axis seeds the interval, the rest narrow it
      if (a == 0 || lo > tn) tn = lo;
      if (a == 0 || hi < tf) tf = hi;
    end
    res.hit = (tn <= tf);
    res.t_near = tn[31:0];
    res.t_far = tf[31:0];
    res.index = r.idx;
    return res;
  endfunction

  // driver: one request per edge when the idle draw allows it and full is low
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        expected_hits.push_back(clip_ray(pending_rays.pop_front()));
      end
      if ((!push || !full) && pending_rays.size() > 0 &&
          $urandom_range(99) >= push_idle_pct) begin
        push <= 1'b1;
        origin_x_i <= pending_rays[0].ox;
        origin_y_i <= pending_rays[0].oy;
        origin_z_i <= pending_rays[0].oz;
        dir_x_i <= pending_rays[0].dx;
        dir_y_i <= pending_rays[0].dy;
        dir_z_i <= pending_rays[0].dz;
        object_index_i <= pending_rays[0].idx;
      end else if (!push || !full) begin
        push <= 1'b0;
      end
    end
  end

  // monitor: check each popped result against the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    rucst_pkg::res_t exp_r;
    if (!rst_ni) begin
      pop <= 1'b0;
      hold_pop_cycles <= 0;
    end else begin
      if (pop && !empty) begin
        if (expected_hits.size() == 0) begin
          $error("result with nothing expected, index %0d", hit_index_o);
          errors++;
        end else begin
          exp_r = expected_hits.pop_front();
          if (hit_o !== exp_r.hit) begin
            $error("hit: expected %0d actual %0d", exp_r.hit, hit_o);
            errors++;
          end
          if (t_near_o !== exp_r.t_near) begin
            $error("t_near: expected %0d actual %0d", exp_r.t_near, t_near_o);
            errors++;
          end
          if (t_far_o !== exp_r.t_far) begin
            $error("t_far: expected %0d actual %0d", exp_r.t_far, t_far_o);
            errors++;
          end
          if (hit_index_o !== exp_r.index) begin
            $error("hit_index: expected %0d actual %0d", exp_r.index, hit_index_o);
            errors++;
          end
        end
      end
      // long hold-off so the block backs up and raises full
      if (hold_pop_req && hold_pop_cycles == 0) begin
        hold_pop_cycles <= 200;
        pop <= 1'b0;
      end else if (hold_pop_cycles > 1) begin
        hold_pop_cycles <= hold_pop_cycles - 1;
        pop <= 1'b0;
      end else begin
        if (hold_pop_cycles == 1) hold_pop_cycles <= 0;
        pop <= ($urandom_range(99) >= pop_idle_pct);
      end
    end
  end

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(5))
      0: return $urandom();
      1: return 32'sh8000_0000 + $urandom_range(3);
      2: return 32'sh7fff_ffff - $urandom_range(3);
      default: return $signed($urandom_range(32'h0006_0000)) - 32'sh0003_0000;
    endcase
  endfunction

  function automatic logic signed [31:0] rand_dir();
    case ($urandom_range(7))
      0: return $urandom();
      1: return $signed($urandom_range(16)) - 32'sd8;
      2: return 32'sh8000_0000;
      3: return 0;
      default: return $signed($urandom_range(32'h0004_0000)) - 32'sh0002_0000;
    endcase
  endfunction

  task automatic add_ray(logic signed [31:0] ox, oy, oz, dx, dy, dz);
    ray_t r;
    r.ox = ox; r.oy = oy; r.oz = oz;
    r.dx = dx; r.dy = dy; r.dz = dz;
    r.idx = rucst_pkg::INDEX_WIDTH'($urandom());
    pending_rays.push_back(r);
  endtask

  task automatic add_random(int n);
    for (int i = 0; i < n; i++)
      add_ray(rand_coord(), rand_coord(), rand_coord(), rand_dir(), rand_dir(), rand_dir());
  endtask

  // wait until all requests have come back, then let the pipe drain
  task automatic drain();
    wait (pending_rays.size() == 0 && !push && expected_hits.size() == 0);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  task automatic write_eps(logic [rucst_pkg::EPS_WIDTH-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    eps_model = value;
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    logic signed [31:0] one_q;
    one_q = 32'sh0001_0000;
    errors = 0;
    eps_model = 7;
    push_idle_pct = 32;
    pop_idle_pct = 86;
    hold_pop_req = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    origin_x_i = '0; origin_y_i = '0; origin_z_i = '0;
    dir_x_i = '0; dir_y_i = '0; dir_z_i = '0;
    object_index_i = '0;
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: axis rays, parallel axes, zero numerators, extremes
    add_ray(-2 * one_q, 0, 0, one_q, 0, 0);
    add_ray(0, 0, 0, one_q, one_q, one_q);
    add_ray(one_q, one_q, -one_q, 6, -6, 7);
    add_ray(-one_q, 0, 0, 0, one_q, 0);
    add_ray(one_q, one_q, one_q, 0, 0, 0);
    add_ray(3 * one_q, 0, 0, 0, one_q, 0);
    add_ray(32'sh8000_0000, 32'sh7fff_ffff, 0, 32'sh8000_0000, 32'sh7fff_ffff, 1);
    add_ray(32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff, 1, -1, 32'sh8000_0000);
    add_ray(0, 0, 0, -1, 1, -7);
    add_ray(-one_q, -one_q, -one_q, -one_q, -one_q, -one_q);
    add_ray(one_q / 2, -one_q / 2, 0, 32'sh0000_0100, -32'sh0000_0100, 32'sh7fff_ffff);
    add_ray(32'shffff_ffff, 32'sh0000_ffff, 32'sh8000_0001, 2, 3, 4);
    add_ray(0, 2 * one_q, 0, one_q, -one_q, 0);
    add_ray(-1, -1, -1, -1, -1, -1);
    pending_rays[0].idx = 16'hffff;
    pending_rays[1].idx = 16'h0000;
    add_random(300);
    drain();

    // zero epsilon: only exact zero directions are parallel
    write_eps(16'h0000);
    push_idle_pct = 86;
    pop_idle_pct = 32;
    add_ray(0, 0, 0, 1, -1, 0);
    add_random(300);
    drain();

    // largest epsilon, and a long result stall while requests keep coming
    write_eps(16'hffff);
    push_idle_pct = 0;
    pop_idle_pct = 0;
    add_ray(0, 0, 0, 32'sh0000_fffe, 32'sh0000_ffff, 32'sh0001_0000);
    add_random(300);
    // raise the hold request between edges so the monitor sees it once
    @(negedge clk_i);
    hold_pop_req = 1'b1;
    @(negedge clk_i);
    hold_pop_req = 1'b0;
    drain();

    write_eps(16'd7);
    push_idle_pct = 10;
    pop_idle_pct = 10;
    add_random(330);
    drain();

    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
